>>> hdl/dft_pkg.sv
// ----------------------------------------------------------------------------
// dft_pkg: shared types and constants for the depth-first traversal block
// Beat formats, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dft_pkg;

    localparam int VERTEX_W = 4;
    localparam int ROW_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int VCOUNT_W = 5;

    // a traversal never emits more vertices than this
    localparam logic [COUNT_W-1:0] RESULT_LIMIT = 5'd16;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [3:0]          row_index;
        logic [ROW_W-1:0]    row_bits;
        logic [VERTEX_W-1:0] start_vertex;
    } req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

>>> hdl/dft_adj_store.sv
// ----------------------------------------------------------------------------
// dft_adj_store: adjacency row store
// One row written per load beat, one row read per cycle; cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dft_adj_store
    import dft_pkg::*;
#(
    parameter int ROWS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_addr,
    input  wire logic [ROWS-1:0]         wr_data,
    input  wire logic [$clog2(ROWS)-1:0] rd_addr,
    output logic      [ROWS-1:0]         rd_data
);

    logic [ROWS-1:0] rows_reg [ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            rows_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rows_reg[rd_addr];

endmodule

`default_nettype wire

>>> hdl/dft_lowbit.sv
// ----------------------------------------------------------------------------
// dft_lowbit: lowest-set-bit encoder
// Picks the lowest unvisited neighbor out of a candidate row.
// ----------------------------------------------------------------------------
`default_nettype none

module dft_lowbit
    import dft_pkg::*;
#(
    parameter int ROWS = 16
) (
    input  wire logic [ROWS-1:0]     cand,
    output logic                     found,
    output logic      [VERTEX_W-1:0] idx
);

    always_comb
    begin
        idx = '0;
        // scan downward so the lowest set bit wins
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = VERTEX_W'(i);
            end
        end
    end

    assign found = |cand;

endmodule

`default_nettype wire

>>> hdl/depth_first_traversal.sv
// ----------------------------------------------------------------------------
// depth_first_traversal: depth-first preorder over an adjacency matrix
// Loads rows, then walks the graph from a start vertex with an explicit stack.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_data): a load beat (mode 0) writes
//   one adjacency row. A start beat (mode 1) begins a traversal; req_stall
//   stays high until the final vertex has been placed in the output
//   register. A start_vertex at or above MAX_VERTICES is taken and dropped
//   with no result.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one beat per visited vertex,
//   in depth-first preorder, with last set on the final one.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes vertex_count; ready
//   whenever no traversal is running.
//   Timing: the sequencer makes one step per cycle through the lowest-bit
//   encoder, either a push with one vertex emitted or a pop. After the last
//   push or pop it passes through ST_FINAL, which places the final vertex
//   in the output register once that register is free. A stalled receiver
//   holds the output register; the sequencer waits on any push step until
//   the register is free.
//   Reset clears the adjacency rows, sets vertex_count to 16, and idles.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_first_traversal
    import dft_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire req_t                req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output rsp_t                     rsp_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [VCOUNT_W-1:0] cfg_data
);

    // rows above 15 can never be loaded, so storage stops at 16
    localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int IW   = $clog2(ROWS);

    state_t state_reg, state_next;

    logic [VCOUNT_W-1:0] vcount_reg;
    logic [ROWS-1:0]     visited_reg, visited_next;
    logic [COUNT_W-1:0]  depth_reg, depth_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [VERTEX_W-1:0] pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_data_reg, rsp_data_next;
    logic [VERTEX_W-1:0] stack_reg [ROWS];

    logic                stack_we;
    logic [IW-1:0]       stack_waddr;
    logic [VERTEX_W-1:0] stack_wdata;
    logic [COUNT_W-1:0]  depth_m1;
    logic [VERTEX_W-1:0] top_vertex;

    logic                req_acc;
    logic                adj_we;
    logic                start_ok;
    logic [ROWS-1:0]     adj_row;
    logic [ROWS-1:0]     scan;
    logic [ROWS-1:0]     cand;
    logic                cand_found;
    logic [VERTEX_W-1:0] cand_idx;
    logic                out_free;
    logic                walk_done;

    assign req_acc   = req_valid && !req_stall;
    assign adj_we    = req_acc && (req_data.mode == MODE_LOAD)
                       && (int'(req_data.row_index) < MAX_VERTICES);
    assign start_ok  = int'(req_data.start_vertex) < MAX_VERTICES;
    assign depth_m1  = depth_reg - COUNT_W'(1);
    assign top_vertex = stack_reg[depth_m1[IW-1:0]];
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign walk_done = (depth_reg == '0) || (count_reg == RESULT_LIMIT);

    dft_adj_store #(
        .ROWS (ROWS)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adj_we),
        .wr_addr (req_data.row_index[IW-1:0]),
        .wr_data (req_data.row_bits[ROWS-1:0]),
        .rd_addr (top_vertex[IW-1:0]),
        .rd_data (adj_row)
    );

    // neighbors 1 .. vertex_count-1; bits past ROWS never exist
    always_comb
    begin
        for (int j = 0; j < ROWS; j++)
        begin
            scan[j] = (j != 0) && (VCOUNT_W'(j) < vcount_reg);
        end
    end

    assign cand = adj_row & scan & ~visited_reg;

    dft_lowbit #(
        .ROWS (ROWS)
    ) u_pick (
        .cand  (cand),
        .found (cand_found),
        .idx   (cand_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req_data.mode == MODE_START) && start_ok)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        stack_we       = 1'b0;
        stack_waddr    = depth_reg[IW-1:0];
        stack_wdata    = cand_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req_data.mode == MODE_START) && start_ok)
                begin
                    for (int j = 0; j < ROWS; j++)
                    begin
                        visited_next[j] = (req_data.start_vertex == VERTEX_W'(j));
                    end
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = req_data.start_vertex;
                    depth_next  = COUNT_W'(1);
                    count_next  = COUNT_W'(1);
                    pend_next   = req_data.start_vertex;
                end
            end
            ST_STEP:
            begin
                if (!walk_done)
                begin
                    if (cand_found)
                    begin
                        // release the pending vertex; the new one waits for its last flag
                        if (out_free)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_data_next.vertex = pend_reg;
                            rsp_data_next.last   = 1'b0;
                            pend_next            = cand_idx;
                            visited_next         = visited_reg | (ROWS'(1) << cand_idx);
                            count_next           = count_reg + COUNT_W'(1);
                            if (depth_reg < COUNT_W'(ROWS))
                            begin
                                stack_we   = 1'b1;
                                depth_next = depth_reg + COUNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        depth_next = depth_m1;
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_data_next.vertex = pend_reg;
                    rsp_data_next.last   = 1'b1;
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= VCOUNT_RESET;
            depth_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        visited_reg  <= visited_next;
        pend_reg     <= pend_next;
        rsp_data_reg <= rsp_data_next;
        if (stack_we)
        begin
            stack_reg[stack_waddr] <= stack_wdata;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

>>> hdl/dft_checker.sv
// ----------------------------------------------------------------------------
// dft_checker: port-level checks for the depth-first traversal block
// Watches the request, response and config channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dft_checker
    import dft_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire req_t                req_data,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire rsp_t                rsp_data,
    input wire logic                cfg_ready
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response beat changed while stalled");

    // a valid start beat locks out further requests while the walk runs
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.mode == MODE_START)
        && (int'(req_data.start_vertex) < MAX_VERTICES) |=> req_stall)
        else $error("start beat did not begin a traversal");

    // a load or out-of-range start does not hold the channel
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && ((req_data.mode == MODE_LOAD)
        || (int'(req_data.start_vertex) >= MAX_VERTICES)) |=> !req_stall)
        else $error("single-cycle request held the channel");

    // config is open exactly when no traversal is running
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !req_stall)
        else $error("config ready while traversal running");

    // a traversal ends with its last beat on the output as requests reopen
    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_stall) |-> rsp_valid && rsp_data.last)
        else $error("requests reopened without a final beat");

endmodule

bind depth_first_traversal dft_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_dft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
